[rtl/core/assert_macros.svh]
// Assertion macros for the I2C write core; used by the bus phase sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define I2CW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define I2CW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/i2cw_pkg.sv]
// Types and constants for the I2C two-byte write core.
package i2cw_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BITS = 2'd1;
  localparam logic [1:0] PH_ACK  = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DEV_NAK = 2'd1;
  localparam logic [1:0] STAT_CMD_NAK = 2'd2;

  localparam logic [2:0] LAST_BIT = 3'd7;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic       error_sticky;
    logic [1:0] status;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       scl_level;
  } res_t;

endpackage

[rtl/core/i2cw_fsm.sv]
// Bus phase sequencer: state registers and the next result of one transaction.
`include "assert_macros.svh"

module i2cw_fsm
  import i2cw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic       operation,
  input  logic [7:0] device_byte,
  input  logic [7:0] command_byte,
  input  logic       sda_sample,
  output res_t       res_nxt
);

  logic [1:0] phase_r, phase_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic       second_r, second_nxt;
  logic [1:0] status_r, status_nxt;
  logic       err_r, err_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       done;

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    pend_nxt    = pend_r;
    second_nxt  = second_r;
    status_nxt  = status_r;
    err_nxt     = err_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    done        = 1'b0;
    if (operation == OP_BEGIN) begin
      if (phase_r == PH_IDLE) begin
        shift_nxt   = device_byte;
        pend_nxt    = command_byte;
        second_nxt  = 1'b0;
        bit_cnt_nxt = 3'd0;
        status_nxt  = STAT_OK;
        scl_nxt     = 1'b0;
        sda_nxt     = 1'b0;
        phase_nxt   = PH_BITS;
      end
    end else begin
      case (phase_r)
        PH_BITS: begin
          sda_nxt   = shift_r[7];
          scl_nxt   = 1'b0;
          shift_nxt = {shift_r[6:0], 1'b0};
          if (bit_cnt_r == LAST_BIT) begin
            bit_cnt_nxt = 3'd0;
            phase_nxt   = PH_ACK;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
          end
        end
        PH_ACK: begin
          sda_nxt = 1'b1;
          scl_nxt = 1'b0;
          if (sda_sample) begin
            // NAK: abort straight to stop
            status_nxt = second_r ? STAT_CMD_NAK : STAT_DEV_NAK;
            err_nxt    = 1'b1;
            phase_nxt  = PH_STOP;
          end else if (!second_r) begin
            shift_nxt   = pend_r;
            second_nxt  = 1'b1;
            bit_cnt_nxt = 3'd0;
            phase_nxt   = PH_BITS;
          end else begin
            status_nxt = STAT_OK;
            phase_nxt  = PH_STOP;
          end
        end
        PH_STOP: begin
          scl_nxt     = 1'b1;
          sda_nxt     = 1'b1;
          second_nxt  = 1'b0;
          bit_cnt_nxt = 3'd0;
          phase_nxt   = PH_IDLE;
          done        = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res_nxt.scl_level    = scl_nxt;
    res_nxt.sda_level    = sda_nxt;
    res_nxt.busy_res     = (phase_nxt != PH_IDLE);
    res_nxt.done_res     = done;
    res_nxt.status       = status_nxt;
    res_nxt.error_sticky = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bit_cnt_r <= 3'd0;
      second_r <= 1'b0;
      status_r <= STAT_OK;
      err_r    <= 1'b0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      second_r <= second_nxt;
      status_r <= status_nxt;
      err_r    <= err_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      shift_r <= shift_nxt;
      pend_r  <= pend_nxt;
    end
  end

  `I2CW_ASSERT(a_bitcnt_in_bits, clk, rst_n, (bit_cnt_r != 3'd0) |-> (phase_r == PH_BITS), "bit count running outside data phase")
  `I2CW_ASSERT(a_stop_to_idle, clk, rst_n, (step_en && operation == OP_TICK && phase_r == PH_STOP) |=> (phase_r == PH_IDLE && scl_r && sda_r), "stop did not release bus")
  `I2CW_ASSERT(a_err_sticky, clk, rst_n, !$fell(err_r), "error flag cleared without reset")
  `I2CW_ASSERT(a_second_active, clk, rst_n, second_r |-> (phase_r != PH_IDLE), "second byte flag set while idle")

endmodule

[rtl/core/i2cw_outbuf.sv]
// Result register between the sequencer and the output stream.
module i2cw_outbuf
  import i2cw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  input  logic out_tready,
  output logic out_tvalid,
  output res_t res_out,
  output logic can_load
);

  logic valid_r;
  res_t res_r;

  // Take a new result when empty or when the held one leaves this cycle.
  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign res_out    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

[rtl/core/i2c_master_two_byte_write_core.sv]
// I2C master two-byte write core: takes one item per clock cycle while in_tready is
// high, each a begin or bus phase tick, and returns its result in the cycle after.
// The only limit on rate is the single result register: in_tready is high whenever
// that register is empty or its result is taken in the same cycle, so with out_tready
// held high an item goes in every cycle. Results hold the SCL/SDA drive levels, busy,
// done, the last status (0 ok, 1 device NAK, 2 command NAK) and a sticky error flag.
module i2c_master_two_byte_write_core
  import i2cw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] device_byte, [15:8] command_byte, [16] sda_sample, [23:17] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [5:4] status,
  // [6] error_sticky, [7] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic accept;
  logic can_load;
  res_t res_nxt;
  res_t res_q;

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  i2cw_fsm u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (accept),
    .operation    (in_tuser),
    .device_byte  (in_tdata[7:0]),
    .command_byte (in_tdata[15:8]),
    .sda_sample   (in_tdata[16]),
    .res_nxt      (res_nxt)
  );

  i2cw_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .res_in     (res_nxt),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_out    (res_q),
    .can_load   (can_load)
  );

  assign out_tdata = {1'b0, res_q.error_sticky, res_q.status, res_q.done_res,
                      res_q.busy_res, res_q.sda_level, res_q.scl_level};

endmodule
